### rtl/lkv_pkg.sv
package lkv_pkg;

  localparam int DATA_BITS = 32;
  localparam int KEY_IN_BITS = 32;
  localparam int CAP_BITS = 5;
  localparam logic [CAP_BITS-1:0] CAP_RESET = 5'd16;
  localparam logic [DATA_BITS-1:0] MISS_VALUE = 32'hFFFF_FFFF;

  localparam logic MODE_GET = 1'b0;
  localparam logic MODE_PUT = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_UPDATE
  } state_t;

  // per-cell control for the update cycle
  typedef struct packed {
    logic load;  // take neighbour (or front) contents
    logic trim;  // apply the occupancy limit to the valid mark
    logic keep;  // position lies below the new entry count
  } cell_ctl_t;

endpackage

### rtl/lkv_cell.sv
module lkv_cell #(
  parameter int KEY_BITS = 32
) (
  input  logic                           clk,
  input  logic                           rst,
  input  lkv_pkg::cell_ctl_t             ctl,
  input  logic [KEY_BITS-1:0]            lookup_key,
  input  logic                           prev_valid,
  input  logic [KEY_BITS-1:0]            prev_key,
  input  logic [lkv_pkg::DATA_BITS-1:0]  prev_value,
  output logic                           valid,
  output logic [KEY_BITS-1:0]            key_q,
  output logic [lkv_pkg::DATA_BITS-1:0]  value_q,
  output logic                           match
);
  import lkv_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctl.load) begin
      valid <= prev_valid & (~ctl.trim | ctl.keep);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      key_q   <= prev_key;
      value_q <= prev_value;
    end
  end

  assign match = valid && (key_q == lookup_key);

endmodule

### rtl/lru_key_value_cache_core.sv
// lru key/value store built as a row of cells ordered by recency, most recent at cell 0
// each transaction: parallel key match in the lookup state, then one row shift in update
// a new transaction is taken only in idle or as the previous one commits
// a get waits in the update cycle while the output register is still held
// reset: all valid marks and the entry count clear, capacity returns to 16
module lru_key_value_cache_core #(
  parameter int ENTRIES  = 16,
  parameter int KEY_BITS = 32
) (
  input  logic                                  clk,
  input  logic                                  rst,
  // configuration
  input  logic                                  cfg_we,
  input  logic [lkv_pkg::CAP_BITS-1:0]          cfg_wdata,
  // request channel
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic                                  mode,
  input  logic signed [lkv_pkg::KEY_IN_BITS-1:0] key,
  input  logic signed [lkv_pkg::DATA_BITS-1:0]  value,
  // result channel
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic                                  hit,
  output logic signed [lkv_pkg::DATA_BITS-1:0]  value_read
);
  import lkv_pkg::*;

  localparam int CNT_W = $clog2(ENTRIES + 1);
  localparam int CMP_W = (CNT_W > CAP_BITS) ? CNT_W : CAP_BITS;

  // control state
  state_t              state;
  state_t              state_next;
  logic [CAP_BITS-1:0] capacity;
  logic [CNT_W-1:0]    entry_count;
  logic [CNT_W-1:0]    entry_count_next;

  // captured request
  logic                 mode_q;
  logic [KEY_BITS-1:0]  key_q;
  logic [DATA_BITS-1:0] value_q;

  // registered match vector from the lookup cycle
  logic [ENTRIES-1:0] match_q;
  logic [ENTRIES-1:0] match_now;
  logic               hit_q;

  // row of cells
  logic                 cell_valid [ENTRIES];
  logic [KEY_BITS-1:0]  cell_key   [ENTRIES];
  logic [DATA_BITS-1:0] cell_value [ENTRIES];
  cell_ctl_t            cell_ctl   [ENTRIES];

  // handshake and sequencing
  logic accept;
  logic out_free;
  logic commit;
  logic do_lookup;

  // update-cycle datapath
  logic [DATA_BITS-1:0] sel_value;
  logic [DATA_BITS-1:0] front_value;
  logic [63:0]          key_wide;
  logic [CMP_W-1:0]     cap_w;
  logic [CMP_W-1:0]     cap_eff_w;
  logic [CNT_W-1:0]     cap_eff;
  logic [CNT_W-1:0]     count_inc;
  logic                 insert;

  assign out_free = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_LOOKUP;
      end
      ST_LOOKUP: begin
        state_next = ST_UPDATE;
      end
      ST_UPDATE: begin
        if (commit) state_next = in_valid ? ST_LOOKUP : ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // state outputs: a get holds the update cycle until the result register is free
  always_comb begin
    in_ready  = 1'b0;
    commit    = 1'b0;
    do_lookup = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
      end
      ST_LOOKUP: begin
        do_lookup = 1'b1;
      end
      ST_UPDATE: begin
        commit   = (mode_q == MODE_PUT) || out_free;
        in_ready = commit;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // capacity register
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAP_RESET;
    end else if (cfg_we) begin
      capacity <= cfg_wdata;
    end
  end

  // request capture, key sign-extended then cut to the compare width
  assign key_wide = {{(64 - KEY_IN_BITS){key[KEY_IN_BITS-1]}}, key};

  always_ff @(posedge clk) begin
    if (accept) begin
      mode_q  <= mode;
      key_q   <= key_wide[KEY_BITS-1:0];
      value_q <= value;
    end
  end

  // match capture at the end of the lookup cycle
  always_ff @(posedge clk) begin
    if (do_lookup) begin
      match_q <= match_now;
      hit_q   <= |match_now;
    end
  end

  // value of the hit cell (match vector is one-hot or empty)
  always_comb begin
    sel_value = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      sel_value = sel_value | (cell_value[i] & {DATA_BITS{match_q[i]}});
    end
  end

  assign front_value = (mode_q == MODE_PUT) ? value_q : sel_value;
  assign insert      = commit && (mode_q == MODE_PUT) && !hit_q;

  // new count after an inserting put: full store drops its tail first, then trim to capacity
  assign cap_w     = CMP_W'(capacity);
  assign cap_eff_w = (cap_w > CMP_W'(ENTRIES)) ? CMP_W'(ENTRIES) : cap_w;
  assign cap_eff   = cap_eff_w[CNT_W-1:0];
  assign count_inc = (entry_count == CNT_W'(ENTRIES)) ? CNT_W'(ENTRIES)
                                                      : entry_count + 1'b1;
  assign entry_count_next = (count_inc > cap_eff) ? cap_eff : count_inc;

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= '0;
    end else if (insert) begin
      entry_count <= entry_count_next;
    end
  end

  // the cell row: a hit rotates cells 0..hit position, an insert shifts the whole row
  for (genvar p = 0; p < ENTRIES; p++) begin : g_cell
    logic upto_hit;

    assign upto_hit = |match_q[ENTRIES-1:p];

    always_comb begin
      cell_ctl[p].load = commit && (hit_q ? upto_hit : (mode_q == MODE_PUT));
      cell_ctl[p].trim = !hit_q;
      cell_ctl[p].keep = CNT_W'(p) < entry_count_next;
    end

    if (p == 0) begin : g_front
      lkv_cell #(
        .KEY_BITS (KEY_BITS)
      ) u_cell (
        .clk        (clk),
        .rst        (rst),
        .ctl        (cell_ctl[p]),
        .lookup_key (key_q),
        .prev_valid (1'b1),
        .prev_key   (key_q),
        .prev_value (front_value),
        .valid      (cell_valid[p]),
        .key_q      (cell_key[p]),
        .value_q    (cell_value[p]),
        .match      (match_now[p])
      );
    end else begin : g_rest
      lkv_cell #(
        .KEY_BITS (KEY_BITS)
      ) u_cell (
        .clk        (clk),
        .rst        (rst),
        .ctl        (cell_ctl[p]),
        .lookup_key (key_q),
        .prev_valid (cell_valid[p-1]),
        .prev_key   (cell_key[p-1]),
        .prev_value (cell_value[p-1]),
        .valid      (cell_valid[p]),
        .key_q      (cell_key[p]),
        .value_q    (cell_value[p]),
        .match      (match_now[p])
      );
    end
  end

  // result register, loaded when a get commits
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (commit && (mode_q == MODE_GET)) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit && (mode_q == MODE_GET)) begin
      hit        <= hit_q;
      value_read <= hit_q ? sel_value : MISS_VALUE;
    end
  end

endmodule

### test/tb_lru_key_value_cache_core.sv
module tb_lru_key_value_cache_core;
  timeunit 1ns;
  timeprecision 1ps;

  import lkv_pkg::*;

  localparam int ENTRIES = 16;
  localparam int KEY_BITS = 32;
  localparam int RESET_CYCLES = 7;
  localparam int SETTLE_CYCLES = 12;    // covers the lookup and update of a trailing transaction
  localparam int HOLD_CYCLES = 160;     // long receiver back-pressure stretch
  localparam int CYCLE_LIMIT = 400000;  // generous ceiling on the whole run
  localparam int ROUNDS = 9;
  localparam int ROUND_ITEMS = 150;
  localparam int POOL_SIZE = 24;
  localparam int SCRIPT_ROWS = 21;

  // one expected get answer
  typedef struct packed {
    logic hit;
    logic [DATA_BITS-1:0] data;
  } lookup_result_t;

  // directed script: either a request or a capacity write
  typedef enum logic {
    ROW_REQUEST,
    ROW_CAPACITY
  } row_kind_t;

  typedef struct packed {
    row_kind_t kind;
    logic op;
    logic [KEY_IN_BITS-1:0] k;
    logic [DATA_BITS-1:0] v;
    logic typed;             // expectation written into the row
    lookup_result_t answer;
  } script_row_t;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [CAP_BITS-1:0] cfg_wdata;
  logic in_valid;
  logic in_ready;
  logic req_mode;
  logic signed [KEY_IN_BITS-1:0] req_key;
  logic signed [DATA_BITS-1:0] req_value;
  logic out_valid;
  logic out_ready;
  logic rsp_hit;
  logic signed [DATA_BITS-1:0] rsp_value;

  // shadow of the cache contents, kept in recency order like the block
  logic [KEY_IN_BITS-1:0] slot_key [ENTRIES];
  logic [DATA_BITS-1:0] slot_data [ENTRIES];
  logic slot_live [ENTRIES];
  logic [3:0] recency [ENTRIES];
  logic [4:0] live_count;
  logic [CAP_BITS-1:0] cap_shadow;

  lookup_result_t pending_results[$];
  script_row_t script [SCRIPT_ROWS];
  logic [KEY_IN_BITS-1:0] key_pool [POOL_SIZE];

  int fail_count;
  int cycle_count;
  int send_idle_pct;
  int recv_idle_pct;
  logic hold_request;
  logic hold_done;
  int hold_count;

  lru_key_value_cache_core #(
    .ENTRIES(ENTRIES),
    .KEY_BITS(KEY_BITS)
  ) uut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .mode(req_mode),
    .key(req_key),
    .value(req_value),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .hit(rsp_hit),
    .value_read(rsp_value)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // run ceiling
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic note_failure(input string msg);
    fail_count++;
    if (fail_count <= 10) $display("%s", msg);
  endtask

  // ---------------- shadow cache ----------------

  // recency position of a live entry with this key, ENTRIES when absent
  function automatic int locate_key(input logic [KEY_IN_BITS-1:0] k);
    logic [KEY_BITS-1:0] wanted;
    wanted = k[KEY_BITS-1:0];
    for (int p = 0; p < int'(live_count) && p < ENTRIES; p++) begin
      if (slot_live[recency[p]] && slot_key[recency[p]][KEY_BITS-1:0] == wanted) return p;
    end
    return ENTRIES;
  endfunction

  // move the slot at position pos to the front, shifting the rest down
  task automatic promote(input int pos);
    logic [3:0] s;
    if (pos >= ENTRIES) return;
    s = recency[pos];
    for (int p = pos; p > 0; p--) recency[p] = recency[p-1];
    recency[0] = s;
  endtask

  task automatic drop_least_recent();
    if (live_count == 0) return;
    live_count--;
    slot_live[recency[live_count]] = 1'b0;
  endtask

  // apply one transaction to the shadow cache and work out its answer
  task automatic lru_apply(input logic op, input logic [KEY_IN_BITS-1:0] k,
                           input logic [DATA_BITS-1:0] v,
                           output bit answers, output lookup_result_t res);
    int pos;
    int limit;
    logic [3:0] s;
    pos = locate_key(k);
    limit = (int'(cap_shadow) > ENTRIES) ? ENTRIES : int'(cap_shadow);
    answers = 1'b0;
    res = '{hit: 1'b0, data: MISS_VALUE};
    if (op == MODE_GET) begin
      answers = 1'b1;
      if (pos < ENTRIES) begin
        promote(pos);
        res.hit = 1'b1;
        res.data = slot_data[recency[0]];
      end
    end else if (pos < ENTRIES) begin
      // update in place, entry becomes most recent
      promote(pos);
      slot_data[recency[0]] = v;
    end else begin
      // drop the least recent if full, insert into the free slot, then trim down to the capacity
      if (live_count >= ENTRIES) drop_least_recent();
      promote(int'(live_count));
      s = recency[0];
      slot_key[s] = k;
      slot_data[s] = v;
      slot_live[s] = 1'b1;
      live_count++;
      while (int'(live_count) > limit) drop_least_recent();
    end
  endtask

  // ---------------- request side ----------------

  // offer one transaction, predict its answer once it is taken
  task automatic offer(input logic op, input logic [KEY_IN_BITS-1:0] k,
                       input logic [DATA_BITS-1:0] v, input logic typed,
                       input lookup_result_t typed_res);
    bit answers;
    lookup_result_t res;
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    req_mode <= op;
    req_key <= k;
    req_value <= v;
    do @(posedge clk); while (!in_ready);
    lru_apply(op, k, v, answers, res);
    if (answers) pending_results.push_back(typed ? typed_res : res);
  endtask

  // capacity is only changed with the block idle
  task automatic write_capacity(input logic [CAP_BITS-1:0] c);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    // a trailing put gives no answer, so let it finish
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= c;
    @(posedge clk);
    cfg_we <= 1'b0;
    cap_shadow = c;
  endtask

  // ---------------- result side ----------------

  // random back-pressure, plus one long hold when asked for
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_request && !hold_done) begin
      out_ready <= 1'b0;
      hold_count <= hold_count + 1;
      if (hold_count == HOLD_CYCLES) hold_done <= 1'b1;
    end else begin
      out_ready <= (recv_idle_pct == 0) || ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // compare each answer with the oldest expectation
  always @(posedge clk) begin
    lookup_result_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        note_failure($sformatf("unexpected answer hit=%0b value=%h", rsp_hit, rsp_value));
      end else begin
        want = pending_results.pop_front();
        if (rsp_hit !== want.hit || rsp_value !== want.data)
          note_failure($sformatf("answer mismatch: hit exp %0b got %0b, value exp %h got %h",
                                 want.hit, rsp_hit, want.data, rsp_value));
      end
    end
  end

  // ---------------- stimulus ----------------

  initial begin
    lookup_result_t no_answer;
    lookup_result_t miss;
    int pool_span;
    int eff_cap;
    logic op;
    logic [KEY_IN_BITS-1:0] k;
    logic [CAP_BITS-1:0] round_cap [ROUNDS];

    // all inputs known from time zero
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    in_valid = 1'b0;
    req_mode = MODE_GET;
    req_key = '0;
    req_value = '0;
    fail_count = 0;
    cycle_count = 0;
    send_idle_pct = 34;
    recv_idle_pct = 57;
    hold_request = 1'b0;
    hold_done = 1'b0;
    hold_count = 0;

    // shadow reset: nothing live, identity order, full capacity
    for (int i = 0; i < ENTRIES; i++) begin
      slot_key[i] = '0;
      slot_data[i] = '0;
      slot_live[i] = 1'b0;
      recency[i] = i[3:0];
    end
    live_count = '0;
    cap_shadow = CAP_RESET;

    no_answer = '{hit: 1'b0, data: '0};
    miss = '{hit: 1'b0, data: MISS_VALUE};

    // directed: key/value extremes, update, lowering capacity below the count,
    // capacity zero and a capacity that saturates
    script[0]  = '{ROW_REQUEST,  MODE_GET, 32'h0000_0000, 32'h0000_0000, 1'b1, miss};
    script[1]  = '{ROW_REQUEST,  MODE_GET, 32'h8000_0000, 32'hFFFF_FFFF, 1'b1, miss};
    script[2]  = '{ROW_REQUEST,  MODE_PUT, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0, no_answer};
    script[3]  = '{ROW_REQUEST,  MODE_GET, 32'h7FFF_FFFF, 32'h0000_0000, 1'b1,
                   '{hit: 1'b1, data: 32'h8000_0000}};
    script[4]  = '{ROW_REQUEST,  MODE_PUT, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0, no_answer};
    script[5]  = '{ROW_REQUEST,  MODE_PUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, no_answer};
    script[6]  = '{ROW_REQUEST,  MODE_PUT, 32'h0000_0000, 32'h0000_0000, 1'b0, no_answer};
    script[7]  = '{ROW_REQUEST,  MODE_PUT, 32'h7FFF_FFFF, 32'h1234_5678, 1'b0, no_answer};
    script[8]  = '{ROW_REQUEST,  MODE_GET, 32'h8000_0000, 32'h0000_0000, 1'b0, no_answer};
    script[9]  = '{ROW_REQUEST,  MODE_GET, 32'hFFFF_FFFF, 32'h0000_0000, 1'b0, no_answer};
    script[10] = '{ROW_CAPACITY, MODE_GET, 32'h0000_0000, 32'd2,         1'b0, no_answer};
    script[11] = '{ROW_REQUEST,  MODE_GET, 32'h0000_0000, 32'h0000_0000, 1'b0, no_answer};
    script[12] = '{ROW_REQUEST,  MODE_PUT, 32'h0000_0005, 32'hA5A5_A5A5, 1'b0, no_answer};
    script[13] = '{ROW_REQUEST,  MODE_GET, 32'h7FFF_FFFF, 32'h0000_0000, 1'b0, no_answer};
    script[14] = '{ROW_REQUEST,  MODE_GET, 32'h0000_0005, 32'h0000_0000, 1'b0, no_answer};
    script[15] = '{ROW_CAPACITY, MODE_GET, 32'h0000_0000, 32'd0,         1'b0, no_answer};
    script[16] = '{ROW_REQUEST,  MODE_PUT, 32'h0000_0009, 32'h0000_0009, 1'b0, no_answer};
    script[17] = '{ROW_REQUEST,  MODE_GET, 32'h0000_0009, 32'h0000_0000, 1'b1, miss};
    script[18] = '{ROW_CAPACITY, MODE_GET, 32'h0000_0000, 32'd31,        1'b0, no_answer};
    script[19] = '{ROW_REQUEST,  MODE_PUT, 32'h0000_0000, 32'h55AA_55AA, 1'b0, no_answer};
    script[20] = '{ROW_REQUEST,  MODE_GET, 32'h0000_0000, 32'h0000_0000, 1'b0, no_answer};

    // capacity per random round, extremes included
    round_cap = '{5'd16, 5'd1, 5'd31, 5'd0, 5'd3, 5'd17, 5'd8, 5'd2, 5'd16};

    // key pool keeps hits frequent; extremes seeded in
    key_pool[0] = 32'h0000_0000;
    key_pool[1] = 32'hFFFF_FFFF;
    key_pool[2] = 32'h8000_0000;
    key_pool[3] = 32'h7FFF_FFFF;
    for (int i = 4; i < POOL_SIZE; i++) key_pool[i] = $urandom;

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int r = 0; r < SCRIPT_ROWS; r++) begin
      if (script[r].kind == ROW_CAPACITY)
        write_capacity(script[r].v[CAP_BITS-1:0]);
      else
        offer(script[r].op, script[r].k, script[r].v, script[r].typed, script[r].answer);
    end

    for (int rnd = 0; rnd < ROUNDS; rnd++) begin
      write_capacity(round_cap[rnd]);
      // idling pattern: sender light / receiver heavy, then swapped, then none
      if (rnd < 3) begin
        send_idle_pct = 34;
        recv_idle_pct = 57;
      end else if (rnd < 6) begin
        send_idle_pct = 57;
        recv_idle_pct = 34;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      // long receiver stall with the sender pushing flat out, so the input backs up
      if (rnd == 6) hold_request <= 1'b1;

      // refresh part of the pool so stale entries linger alongside new ones
      for (int i = 0; i < 4; i++) key_pool[4 + $urandom_range(POOL_SIZE - 5)] = $urandom;

      eff_cap = (int'(round_cap[rnd]) > ENTRIES) ? ENTRIES : int'(round_cap[rnd]);
      pool_span = (eff_cap + 6 > POOL_SIZE) ? POOL_SIZE : eff_cap + 6;

      for (int n = 0; n < ROUND_ITEMS; n++) begin
        op = ($urandom_range(1) == 0) ? MODE_GET : MODE_PUT;
        if ($urandom_range(99) < 88)
          k = key_pool[$urandom_range(pool_span - 1)];
        else
          k = $urandom;
        offer(op, k, $urandom, 1'b0, no_answer);
      end
    end

    // drain, then leave room for anything still in flight
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (fail_count == 0 && pending_results.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

### sim.f
rtl/lkv_pkg.sv
rtl/lkv_cell.sv
rtl/lru_key_value_cache_core.sv
test/tb_lru_key_value_cache_core.sv
